### rtl/tsms_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helpers for the time sync message supervisor
// no dependencies; used by every module of the block by scoped name

package tsms_pkg;

	localparam int MSG_BYTES_DEF = 20;

	localparam logic [7:0] SAVE_PERIOD_RST = 8'd60;
	localparam logic [7:0] LINK_TIMEOUT_RST = 8'd10;
	localparam logic [7:0] SEC_LIMIT = 8'd56;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_ONE = 8'h31;
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CASE_OFS = 8'd32;

	// rtc register codes
	localparam logic [2:0] RTC_SECOND = 3'd0;
	localparam logic [2:0] RTC_NONE = 3'd6;

	// sync status codes
	localparam logic [1:0] SYNC_NONE = 2'd0;
	localparam logic [1:0] SYNC_MASTER = 2'd1;
	localparam logic [1:0] SYNC_GPS = 2'd2;

	// configuration register indexes
	localparam logic CFG_SAVE_PERIOD = 1'b0;
	localparam logic CFG_LINK_TIMEOUT = 1'b1;

	localparam int OUT_DATA_W = 88;

	typedef enum logic [1:0] {
		REQ_BYTE = 2'd0,
		REQ_EOM = 2'd1,
		REQ_TICK = 2'd2
	} req_t;

	typedef struct packed {
		logic [1:0] req;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] set_cnt;
		logic [31:0] msg_cnt;
		logic [3:0] flags;
		logic link;
		logic [1:0] sync;
	} status_t;

	typedef struct packed {
		logic wrote;
		logic [5:0][7:0] vals;
		status_t st;
	} bundle_t;

	function automatic logic [7:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] h;
		logic [7:0] l;
		h = hi - CH_ZERO;
		l = lo - CH_ZERO;
		return (h << 3) + (h << 1) + l;
	endfunction

	function automatic logic letter_is(input logic [7:0] c, input logic [7:0] up);
		return (c == up) || (c == (up + CASE_OFS));
	endfunction

endpackage

### rtl/time_sync_message_supervisor_core.sv
`timescale 1ns / 1ps
// a word accepted is held in the input register, then evaluated into the result register
// once the emitter is free, and its first result word is offered from there
// throughput: one input word per cycle when the sink is ready and each yields one result
// word; a message that writes the rtc holds the single output register for seven words
// reset: arst_n clears all but item_s1, bundle_q at once; save period 60, link timeout 10

module time_sync_message_supervisor_core #(
	parameter int MSG_BYTES = tsms_pkg::MSG_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // rx_byte
	input  logic [1:0]                      s_axis_tuser,  // req_type
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [tsms_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // rtc_reg, rtc_value, sync_state,
	                                                      // link_connected, gps1_ok, gps2_ok,
	                                                      // power1_ok, power2_ok,
	                                                      // message_count, set_count
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [7:0]                      cfg_data
);

	logic valid_s1;
	tsms_pkg::item_t item_s1;
	logic [7:0] save_period_q;
	logic [7:0] link_timeout_q;
	logic adv;
	logic free;
	tsms_pkg::bundle_t nxt;

	assign adv = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= '{req: s_axis_tuser, rx_byte: s_axis_tdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			save_period_q <= tsms_pkg::SAVE_PERIOD_RST;
			link_timeout_q <= tsms_pkg::LINK_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tsms_pkg::CFG_SAVE_PERIOD: save_period_q <= cfg_data;
				tsms_pkg::CFG_LINK_TIMEOUT: link_timeout_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tsms_eval #(
		.MSG_BYTES(MSG_BYTES)
	) u_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (adv),
		.item         (item_s1),
		.save_period  (save_period_q),
		.link_timeout (link_timeout_q),
		.nxt          (nxt)
	);

	tsms_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv),
		.bundle        (nxt),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### rtl/tsms_eval.sv
`timescale 1ns / 1ps
// message buffer, countdowns, flags and counters; evaluates one word per commit
// depends on tsms_pkg

module tsms_eval #(
	parameter int MSG_BYTES = tsms_pkg::MSG_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  tsms_pkg::item_t   item,
	input  logic [7:0]        save_period,
	input  logic [7:0]        link_timeout,
	output tsms_pkg::bundle_t nxt
);

	localparam int POS_W = $clog2(MSG_BYTES + 1);
	localparam int IDX_W = $clog2(MSG_BYTES);

	logic [7:0] buf_q [MSG_BYTES];
	logic [7:0] buf_d [MSG_BYTES];
	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0] save_cd_q, save_cd_d;
	logic [7:0] link_cd_q, link_cd_d;
	logic [1:0] status_q, status_d;
	logic link_q, link_d;
	logic [3:0] flags_q, flags_d;
	logic [31:0] msg_cnt_q, msg_cnt_d;
	logic [31:0] set_cnt_q, set_cnt_d;
	logic match;
	logic wrote;
	logic [7:0] sec;

	assign sec = tsms_pkg::two_digits(buf_q[8], buf_q[9]);
	assign match = (buf_q[0] == tsms_pkg::CH_DOLLAR)
		&& tsms_pkg::letter_is(buf_q[1], tsms_pkg::CH_G)
		&& tsms_pkg::letter_is(buf_q[2], tsms_pkg::CH_P)
		&& tsms_pkg::letter_is(buf_q[3], tsms_pkg::CH_S);

	always_comb begin
		buf_d = buf_q;
		pos_d = pos_q;
		save_cd_d = save_cd_q;
		link_cd_d = link_cd_q;
		status_d = status_q;
		link_d = link_q;
		flags_d = flags_q;
		msg_cnt_d = msg_cnt_q;
		set_cnt_d = set_cnt_q;
		wrote = 1'b0;
		unique case (tsms_pkg::req_t'(item.req))
			tsms_pkg::REQ_BYTE: begin
				if (pos_q < POS_W'(MSG_BYTES)) begin
					buf_d[pos_q[IDX_W-1:0]] = item.rx_byte;
					pos_d = pos_q + 1'b1;
				end
			end
			tsms_pkg::REQ_EOM: begin
				if (match) begin
					if (save_cd_q == 8'd0) begin
						save_cd_d = save_period;
						if (sec < tsms_pkg::SEC_LIMIT) begin
							wrote = 1'b1;
							set_cnt_d = set_cnt_q + 32'd1;
						end
					end
					status_d = ((buf_q[16] == tsms_pkg::CH_A) || (buf_q[17] == tsms_pkg::CH_A))
						? tsms_pkg::SYNC_GPS : tsms_pkg::SYNC_MASTER;
					link_cd_d = link_timeout;
					link_d = 1'b1;
					flags_d = {buf_q[19] == tsms_pkg::CH_ONE, buf_q[18] == tsms_pkg::CH_ONE,
						buf_q[17] == tsms_pkg::CH_A, buf_q[16] == tsms_pkg::CH_A};
					msg_cnt_d = msg_cnt_q + 32'd1;
				end
				for (int i = 0; i < MSG_BYTES; i++) begin
					buf_d[i] = 8'd0;
				end
				pos_d = '0;
			end
			tsms_pkg::REQ_TICK: begin
				if (save_cd_q != 8'd0) begin
					save_cd_d = save_cd_q - 8'd1;
				end
				if ((link_cd_q == 8'd1) || (link_cd_q == 8'd2)) begin
					link_cd_d = 8'd0;
					status_d = tsms_pkg::SYNC_NONE;
					link_d = 1'b0;
				end else if (link_cd_q > 8'd2) begin
					link_cd_d = link_cd_q - 8'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		nxt.wrote = wrote;
		nxt.vals[0] = sec;
		nxt.vals[1] = tsms_pkg::two_digits(buf_q[10], buf_q[11]);
		nxt.vals[2] = tsms_pkg::two_digits(buf_q[12], buf_q[13]);
		nxt.vals[3] = tsms_pkg::two_digits(buf_q[14], buf_q[15]);
		nxt.vals[4] = tsms_pkg::two_digits(buf_q[4], buf_q[5]);
		nxt.vals[5] = tsms_pkg::two_digits(buf_q[6], buf_q[7]);
		nxt.st.sync = status_d;
		nxt.st.link = link_d;
		nxt.st.flags = flags_d;
		nxt.st.msg_cnt = msg_cnt_d;
		nxt.st.set_cnt = set_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MSG_BYTES; i++) begin
				buf_q[i] <= 8'd0;
			end
			pos_q <= '0;
			save_cd_q <= tsms_pkg::SAVE_PERIOD_RST;
			link_cd_q <= 8'd0;
			status_q <= tsms_pkg::SYNC_NONE;
			link_q <= 1'b0;
			flags_q <= 4'd0;
			msg_cnt_q <= 32'd0;
			set_cnt_q <= 32'd0;
		end else if (commit) begin
			buf_q <= buf_d;
			pos_q <= pos_d;
			save_cd_q <= save_cd_d;
			link_cd_q <= link_cd_d;
			status_q <= status_d;
			link_q <= link_d;
			flags_q <= flags_d;
			msg_cnt_q <= msg_cnt_d;
			set_cnt_q <= set_cnt_d;
		end
	end

`ifndef SYNTH
	a_link_vs_status: assert property (@(posedge clk) disable iff (!arst_n)
		link_q == (status_q != tsms_pkg::SYNC_NONE))
		else $error("link flag and sync status disagree");

	a_eom_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (item.req == tsms_pkg::REQ_EOM) |=> pos_q == '0)
		else $error("byte position not cleared after end of message");
`endif

endmodule

### rtl/tsms_emit.sv
`timescale 1ns / 1ps
// result register and sequencer: six rtc writes when present, then the status word
// depends on tsms_pkg

module tsms_emit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  tsms_pkg::bundle_t               bundle,
	output logic                            free,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [tsms_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // rtc_reg, rtc_value, sync_state,
	                                                      // link_connected, gps1_ok, gps2_ok,
	                                                      // power1_ok, power2_ok,
	                                                      // message_count, set_count
	output logic                            m_axis_tlast
);

	tsms_pkg::bundle_t bundle_q;
	logic valid_q;
	logic [2:0] idx_q;
	logic is_last;
	logic [7:0] value;

	assign is_last = (idx_q == tsms_pkg::RTC_NONE);
	assign free = !valid_q || (m_axis_tready && is_last);
	assign value = is_last ? 8'd0 : bundle_q.vals[idx_q];

	assign m_axis_tvalid = valid_q;
	assign m_axis_tlast = is_last;
	assign m_axis_tdata = {6'd0, bundle_q.st.set_cnt, bundle_q.st.msg_cnt, bundle_q.st.flags,
		bundle_q.st.link, bundle_q.st.sync, value, idx_q};

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= tsms_pkg::RTC_NONE;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= bundle.wrote ? tsms_pkg::RTC_SECOND : tsms_pkg::RTC_NONE;
		end else if (valid_q && m_axis_tready) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

`ifndef SYNTH
	a_write_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !is_last |-> bundle_q.wrote)
		else $error("rtc write word without a write set");

	a_write_steps: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && m_axis_tready && !is_last |=> valid_q && (idx_q == $past(idx_q) + 3'd1))
		else $error("rtc write sequence skipped or stalled");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// testbench for time_sync_message_supervisor_core: sentence bytes, end markers and ticks
// are streamed in, every result word is checked against a built-in behavioral predictor
// depends on tsms_pkg and time_sync_message_supervisor_core

module tb_top;

	localparam int MSG_LEN = tsms_pkg::MSG_BYTES_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DIR_ROWS = 25;
	localparam int PHASE_WORDS = 60;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [7:0] CH_V = 8'h56;

	typedef struct packed {
		logic last;
		logic [31:0] set_cnt;
		logic [31:0] msg_cnt;
		logic [3:0] flags;
		logic link;
		logic [1:0] sync;
		logic [7:0] value;
		logic [2:0] rtc_reg;
	} rtc_word_t;

	typedef struct {
		logic [1:0] req;
		logic [7:0] data;
		bit typed;
		rtc_word_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;  // rx_byte
	logic [1:0] s_axis_tuser = '0;  // req_type
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [tsms_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // rtc_reg, rtc_value, sync_state,
	                                                // link_connected, gps1_ok, gps2_ok,
	                                                // power1_ok, power2_ok,
	                                                // message_count, set_count
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;

	time_sync_message_supervisor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [7:0] save_per = tsms_pkg::SAVE_PERIOD_RST;
	logic [7:0] link_to = tsms_pkg::LINK_TIMEOUT_RST;
	logic [7:0] msg_buf [MSG_LEN] = '{default: 8'h00};
	int buf_pos = 0;
	logic [7:0] save_cd = tsms_pkg::SAVE_PERIOD_RST;
	logic [7:0] link_cd = 8'h00;
	logic [1:0] sync_st = tsms_pkg::SYNC_NONE;
	logic link_up = 1'b0;
	logic [3:0] supply = 4'h0;
	logic [31:0] msg_cnt = '0;
	logic [31:0] set_cnt = '0;

	rtc_word_t rtc_words_pending [$];
	int err_cnt = 0;
	int words_in = 0;
	int words_out = 0;
	int cycle_cnt = 0;
	int src_calm = 0;
	int sink_calm = 0;
	int sink_stall = 0;

	function automatic int draw_wait(ref int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm_left = $urandom_range(10, 40);
		return $urandom_range(0, 18);
	endfunction

	function automatic logic [7:0] pair_value(int hi);
		logic [7:0] h;
		logic [7:0] l;
		h = msg_buf[hi] - tsms_pkg::CH_ZERO;
		l = msg_buf[hi + 1] - tsms_pkg::CH_ZERO;
		return h * 8'd10 + l;
	endfunction

	function automatic void predict_rtc_words(logic [1:0] req, logic [7:0] data);
		logic [7:0] vals [6];
		logic [7:0] sec;
		bit wrote;
		rtc_word_t w;
		wrote = 0;
		case (req)
			tsms_pkg::REQ_BYTE: begin
				if (buf_pos < MSG_LEN) begin
					msg_buf[buf_pos] = data;
					buf_pos++;
				end
			end
			tsms_pkg::REQ_EOM: begin
				// header letters match in either case
				if (msg_buf[0] == tsms_pkg::CH_DOLLAR &&
				    (msg_buf[1] | tsms_pkg::CASE_OFS) ==
				    (tsms_pkg::CH_G | tsms_pkg::CASE_OFS) &&
				    (msg_buf[2] | tsms_pkg::CASE_OFS) ==
				    (tsms_pkg::CH_P | tsms_pkg::CASE_OFS) &&
				    (msg_buf[3] | tsms_pkg::CASE_OFS) ==
				    (tsms_pkg::CH_S | tsms_pkg::CASE_OFS)) begin
					sec = pair_value(8);
					if (save_cd == 0) begin
						save_cd = save_per;
						if (sec < tsms_pkg::SEC_LIMIT) begin
							vals = '{sec, pair_value(10), pair_value(12), pair_value(14),
							         pair_value(4), pair_value(6)};
							set_cnt++;
							wrote = 1;
						end
					end
					sync_st = (msg_buf[16] == tsms_pkg::CH_A || msg_buf[17] == tsms_pkg::CH_A)
						? tsms_pkg::SYNC_GPS : tsms_pkg::SYNC_MASTER;
					link_cd = link_to;
					link_up = 1'b1;
					supply = {msg_buf[19] == tsms_pkg::CH_ONE, msg_buf[18] == tsms_pkg::CH_ONE,
					          msg_buf[17] == tsms_pkg::CH_A, msg_buf[16] == tsms_pkg::CH_A};
					msg_cnt++;
				end
				msg_buf = '{default: 8'h00};
				buf_pos = 0;
			end
			tsms_pkg::REQ_TICK: begin
				if (save_cd != 0)
					save_cd--;
				if (link_cd > 1)
					link_cd--;
				if (link_cd == 1) begin
					sync_st = tsms_pkg::SYNC_NONE;
					link_cd = 0;
					link_up = 1'b0;
				end
			end
			default: ;
		endcase
		w = '0;
		w.set_cnt = set_cnt;
		w.msg_cnt = msg_cnt;
		w.flags = supply;
		w.link = link_up;
		w.sync = sync_st;
		if (wrote) begin
			for (int i = 0; i < 6; i++) begin
				w.rtc_reg = tsms_pkg::RTC_SECOND + 3'(i);
				w.value = vals[i];
				rtc_words_pending.push_back(w);
			end
		end
		w.rtc_reg = tsms_pkg::RTC_NONE;
		w.value = 8'h00;
		w.last = 1'b1;
		rtc_words_pending.push_back(w);
	endfunction

	task automatic log_error(string msg);
		$display("error at result word %0d: %s", words_out, msg);
		err_cnt++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			log_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic send_word(logic [1:0] req, logic [7:0] data);
		int gap;
		gap = draw_wait(src_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= data;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_rtc_words(req, data);
		words_in++;
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		while (rtc_words_pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == tsms_pkg::CFG_SAVE_PERIOD)
			save_per = val;
		else
			link_to = val;
	endtask

	task automatic send_sentence(bit broken);
		logic [7:0] s [24];
		int len;
		int r;
		s[0] = tsms_pkg::CH_DOLLAR;
		s[1] = tsms_pkg::CH_G | ($urandom_range(0, 1) ? tsms_pkg::CASE_OFS : 8'h00);
		s[2] = tsms_pkg::CH_P | ($urandom_range(0, 1) ? tsms_pkg::CASE_OFS : 8'h00);
		s[3] = tsms_pkg::CH_S | ($urandom_range(0, 1) ? tsms_pkg::CASE_OFS : 8'h00);
		for (int i = 4; i < 16; i++)
			s[i] = tsms_pkg::CH_ZERO + 8'($urandom_range(0, 9));
		// keep most seconds in the writable range
		if ($urandom_range(0, 3) != 0)
			s[8] = tsms_pkg::CH_ZERO + 8'($urandom_range(0, 5));
		s[16] = $urandom_range(0, 1) ? tsms_pkg::CH_A : CH_V;
		s[17] = $urandom_range(0, 1) ? tsms_pkg::CH_A : CH_V;
		s[18] = $urandom_range(0, 1) ? tsms_pkg::CH_ONE : tsms_pkg::CH_ZERO;
		s[19] = $urandom_range(0, 1) ? tsms_pkg::CH_ONE : tsms_pkg::CH_ZERO;
		for (int i = 20; i < 24; i++)
			s[i] = 8'($urandom_range(0, 255));
		if (broken)
			s[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 5) == 0)
			s[$urandom_range(4, 19)] = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 7);
		len = (r == 0) ? $urandom_range(1, 19) : (r == 1) ? $urandom_range(21, 24) : 20;
		for (int i = 0; i < len; i++)
			send_word(tsms_pkg::REQ_BYTE, s[i]);
		send_word(tsms_pkg::REQ_EOM, 8'($urandom_range(0, 255)));
	endtask

	// result side: random stalls, field compare against the oldest pending word
	always @(posedge clk) begin
		rtc_word_t got;
		rtc_word_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tlast, m_axis_tdata[81:0]};
				if (rtc_words_pending.size() == 0) begin
					log_error("result word with nothing pending");
				end else begin
					want = rtc_words_pending.pop_front();
					check_field("rtc_reg", got.rtc_reg, want.rtc_reg);
					check_field("rtc_value", got.value, want.value);
					check_field("sync_state", got.sync, want.sync);
					check_field("link_connected", got.link, want.link);
					check_field("gps/power flags", got.flags, want.flags);
					check_field("message_count", got.msg_cnt, want.msg_cnt);
					check_field("set_count", got.set_cnt, want.set_cnt);
					check_field("tlast", got.last, want.last);
				end
				words_out++;
				sink_stall = draw_wait(sink_calm);
			end else if (sink_stall > 0) begin
				sink_stall--;
			end
			m_axis_tready <= (sink_stall == 0);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still pending",
			         cycle_cnt, rtc_words_pending.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		dir_row_t dir_tab [DIR_ROWS];
		rtc_word_t idle_word;
		string dir_text;
		logic [7:0] save_set [4];
		logic [7:0] link_set [4];
		int phase_end;
		int r;

		idle_word = '0;
		idle_word.rtc_reg = tsms_pkg::RTC_NONE;
		idle_word.last = 1'b1;
		dir_text = "$gPs123045311224AV10";
		dir_tab[0] = '{tsms_pkg::REQ_TICK, 8'h00, 1'b1, idle_word};
		dir_tab[1] = '{REQ_UNUSED, 8'hff, 1'b1, idle_word};
		dir_tab[2] = '{tsms_pkg::REQ_BYTE, 8'h00, 1'b1, idle_word};
		dir_tab[3] = '{tsms_pkg::REQ_EOM, 8'hff, 1'b1, idle_word};
		for (int i = 0; i < MSG_LEN; i++)
			dir_tab[4 + i] = '{tsms_pkg::REQ_BYTE, dir_text[i], 1'b0, idle_word};
		dir_tab[24] = '{tsms_pkg::REQ_EOM, 8'h00, 1'b0, idle_word};

		// extremes and small values of both registers, zero and one included
		save_set = '{8'd0, 8'd3, 8'd1, 8'd255};
		link_set = '{8'd1, 8'd0, 8'd2, 8'd255};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_word(dir_tab[i].req, dir_tab[i].data);
			if (dir_tab[i].typed) begin
				void'(rtc_words_pending.pop_back());
				rtc_words_pending.push_back(dir_tab[i].want);
			end
		end
		s_axis_tvalid <= 1'b0;

		for (int p = 0; p < 4; p++) begin
			write_reg(tsms_pkg::CFG_SAVE_PERIOD, save_set[p]);
			write_reg(tsms_pkg::CFG_LINK_TIMEOUT, link_set[p]);
			// run the save countdown out so sentences can write the rtc
			while (save_cd != 0)
				send_word(tsms_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
			phase_end = words_in + PHASE_WORDS;
			while (words_in < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					send_sentence(1'b0);
				end else if (r < 65) begin
					send_sentence(1'b1);
				end else if (r < 88) begin
					repeat ($urandom_range(1, 6))
						send_word(tsms_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
				end else begin
					send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				end
			end
			s_axis_tvalid <= 1'b0;
		end

		while (rtc_words_pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d input words over five register settings, checked %0d result words",
		         words_in, words_out);
		$display("%0d matching sentences, %0d rtc write sets", msg_cnt, set_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
